FILE: sv/crsg_pkg.sv
// shared types, constants and functions of the reference signal pilot generator
`default_nettype none
package crsg_pkg;

    localparam int SEQ_OFFSET    = 1600;
    localparam int MAX_PILOTS    = 220;
    localparam int RB_FULL       = 110;
    localparam int SEQ_W         = 31;
    localparam int CID_W         = 9;
    localparam int RB_W          = 7;
    localparam int SLOT_W        = 5;
    localparam int SC_W          = 11;
    localparam int PCNT_W        = 8;
    localparam int SKIP_MAX      = SEQ_OFFSET + 2 * RB_FULL;
    localparam int SKIP_W        = $clog2(SKIP_MAX + 1);
    localparam int CMD_DEPTH     = 2;
    localparam int CMD_PTR_W     = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W     = $clog2(CMD_DEPTH + 1);
    localparam int PILOT_SPACING = 6;
    localparam int SYMS_PER_SLOT = 7;
    localparam int L_LATER_NORM  = 4;
    localparam int L_LATER_EXT   = 3;
    localparam int V_LATER       = 3;
    localparam int SEED_SHIFT_W  = 10;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 16;
    localparam int CFG_DATA_W    = 9;
    localparam int CFG_ADDR_W    = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CELL_ID  = 2'd0,
        CFG_EXT_CP   = 2'd1,
        CFG_RB_COUNT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [SEQ_W-1:0] one;
        logic [SEQ_W-1:0] two;
    } t_lfsr;

    typedef struct packed {
        logic              is_start;
        logic              later;
        logic [SEQ_W-1:0]  seed;
        logic [SKIP_W-1:0] skip;
    } t_cmd;

    // rb_count clamped to 1..MAX_PILOTS/2
    function automatic logic [RB_W-1:0] eff_rb(input logic [RB_W-1:0] rb);
        logic [RB_W-1:0] res;
        if (rb == '0) begin
            res = RB_W'(1);
        end else if (rb > RB_W'(MAX_PILOTS / 2)) begin
            res = RB_W'(MAX_PILOTS / 2);
        end else begin
            res = rb;
        end
        return res;
    endfunction

    // x mod 6 via reciprocal multiply, quotient is exact or one low
    function automatic logic [2:0] cid_mod6(input logic [CID_W-1:0] x);
        logic [15:0] prod;
        logic [6:0]  quo;
        logic [9:0]  rem;
        logic [2:0]  res;
        prod = 16'(x) * 16'd85;
        quo  = prod[15:9];
        rem  = 10'(x) - 10'(10'(quo) * 10'(PILOT_SPACING));
        if (rem >= 10'(PILOT_SPACING)) begin
            rem = rem - 10'(PILOT_SPACING);
        end
        res = rem[2:0];
        return res;
    endfunction

    // one step of both gold sequence registers
    function automatic t_lfsr seq_adv(input t_lfsr s);
        t_lfsr res;
        logic  f1;
        logic  f2;
        f1 = s.one[3] ^ s.one[0];
        f2 = s.two[3] ^ s.two[2] ^ s.two[1] ^ s.two[0];
        res.one = {f1, s.one[SEQ_W-1:1]};
        res.two = {f2, s.two[SEQ_W-1:1]};
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: sv/crsg_front.sv
// front end: accepts items, classifies them and forms seed and skip length for starts
`default_nettype none
module crsg_front (
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [crsg_pkg::SLOT_W-1:0]   i_slot,
    input  wire logic                          i_symbol_sel,
    input  wire logic                          i_start_req,
    input  wire logic [crsg_pkg::CID_W-1:0]    i_cell_id,
    input  wire logic                          i_extended_cp,
    input  wire logic [crsg_pkg::RB_W-1:0]     i_rb_count,
    input  wire logic                          i_fifo_full,
    output logic                               o_push,
    output crsg_pkg::t_cmd                     o_cmd
);
    import crsg_pkg::*;

    logic [7:0]            w_sym_idx;
    logic [3:0]            w_l;
    logic [17:0]           w_prod;
    logic                  w_ncp;
    logic [RB_W-1:0]       w_eff;
    logic [RB_W-1:0]       w_rb_gap;

    always_comb begin
        if (!i_symbol_sel) begin
            w_l = 4'd0;
        end else if (i_extended_cp) begin
            w_l = 4'(L_LATER_EXT);
        end else begin
            w_l = 4'(L_LATER_NORM);
        end
        w_ncp     = ~i_extended_cp;
        w_sym_idx = 8'(8'(SYMS_PER_SLOT) * (8'(i_slot) + 8'd1)) + 8'(w_l) + 8'd1;
        w_prod    = 18'(w_sym_idx) * 18'({i_cell_id, 1'b1});
        w_eff     = eff_rb(i_rb_count);
        w_rb_gap  = RB_W'(RB_FULL) - w_eff;
    end

    assign o_s_tready     = ~i_fifo_full;
    assign o_push         = i_s_tvalid & ~i_fifo_full;
    assign o_cmd.is_start = i_start_req;
    assign o_cmd.later    = i_symbol_sel;
    // low 10 bits of the seed never carry into the product term
    assign o_cmd.seed     = SEQ_W'({w_prod, i_cell_id, w_ncp});
    assign o_cmd.skip     = SKIP_W'(SEQ_OFFSET) + SKIP_W'({w_rb_gap, 1'b0});

endmodule
`default_nettype wire

FILE: sv/crsg_cmd_fifo.sv
// short command queue between front end and sequence engine
`default_nettype none
module crsg_cmd_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire crsg_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output crsg_pkg::t_cmd      o_cmd
);
    import crsg_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count;
    logic                 w_do_push;
    logic                 w_do_pop;

    assign o_full    = (r_count == CMD_CNT_W'(CMD_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & ~o_empty;
    assign o_cmd     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/crsg_back.sv
// back end: gold sequence engine, pilot counter and output register
`default_nettype none
module crsg_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [crsg_pkg::CID_W-1:0] i_cell_id,
    input  wire logic [crsg_pkg::RB_W-1:0]  i_rb_count,
    input  wire logic                       i_cmd_empty,
    input  wire crsg_pkg::t_cmd             i_cmd,
    output logic                            o_pop,
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic                            o_i_neg,
    output logic                            o_q_neg,
    output logic [crsg_pkg::SC_W-1:0]       o_subcarrier,
    output logic                            o_last
);
    import crsg_pkg::*;

    typedef enum logic [1:0] {
        ST_READY = 2'b01,
        ST_SKIP  = 2'b10
    } t_back_state;

    t_back_state       r_state, n_state;
    t_lfsr             r_seq, n_seq;
    logic [SKIP_W-1:0] r_skip_left, n_skip_left;
    logic [PCNT_W-1:0] r_pilot_count, n_pilot_count;
    logic              r_run_active, n_run_active;
    logic              r_later, n_later;
    logic [2:0]        r_cid_mod6;
    logic              r_out_valid, n_out_valid;
    logic              r_i_neg, n_i_neg;
    logic              r_q_neg, n_q_neg;
    logic [SC_W-1:0]   r_subcarrier, n_subcarrier;
    logic              r_last, n_last;

    t_lfsr             w_step1;
    t_lfsr             w_step2;
    logic              w_out_free;
    logic [3:0]        w_shift;
    logic [PCNT_W-1:0] w_total;
    logic              w_is_last;

    assign w_step1    = seq_adv(r_seq);
    assign w_step2    = seq_adv(w_step1);
    assign w_out_free = ~r_out_valid | i_m_tready;
    assign w_total    = {eff_rb(i_rb_count), 1'b0};
    assign w_is_last  = ({1'b0, r_pilot_count} + 9'd1) >= {1'b0, w_total};

    always_comb begin
        w_shift = 4'(r_cid_mod6) + (r_later ? 4'(V_LATER) : 4'd0);
        if (w_shift >= 4'(PILOT_SPACING)) begin
            w_shift = w_shift - 4'(PILOT_SPACING);
        end
    end

    always_comb begin
        n_state       = r_state;
        n_seq         = r_seq;
        n_skip_left   = r_skip_left;
        n_pilot_count = r_pilot_count;
        n_run_active  = r_run_active;
        n_later       = r_later;
        n_out_valid   = r_out_valid & ~i_m_tready;
        n_i_neg       = r_i_neg;
        n_q_neg       = r_q_neg;
        n_subcarrier  = r_subcarrier;
        n_last        = r_last;
        o_pop         = 1'b0;
        unique case (r_state)
            ST_READY: begin
                if (!i_cmd_empty) begin
                    if (i_cmd.is_start) begin
                        o_pop         = 1'b1;
                        n_seq.one     = SEQ_W'(1);
                        n_seq.two     = i_cmd.seed;
                        n_skip_left   = i_cmd.skip;
                        n_pilot_count = '0;
                        n_run_active  = 1'b1;
                        n_later       = i_cmd.later;
                        n_state       = ST_SKIP;
                    end else if (!r_run_active) begin
                        // continuation outside a run is dropped
                        o_pop = 1'b1;
                    end else if (w_out_free) begin
                        o_pop         = 1'b1;
                        n_seq         = w_step2;
                        n_out_valid   = 1'b1;
                        n_i_neg       = r_seq.one[0] ^ r_seq.two[0];
                        n_q_neg       = w_step1.one[0] ^ w_step1.two[0];
                        n_subcarrier  = SC_W'(SC_W'(r_pilot_count) * SC_W'(PILOT_SPACING))
                                        + SC_W'(w_shift);
                        n_last        = w_is_last;
                        if (w_is_last) begin
                            n_run_active  = 1'b0;
                            n_pilot_count = '0;
                        end else begin
                            n_pilot_count = r_pilot_count + 1'b1;
                        end
                    end
                end
            end
            ST_SKIP: begin
                if (r_skip_left == '0) begin
                    n_state = ST_READY;
                end else if (r_skip_left == SKIP_W'(1)) begin
                    n_seq       = w_step1;
                    n_skip_left = '0;
                end else begin
                    n_seq       = w_step2;
                    n_skip_left = r_skip_left - SKIP_W'(2);
                end
            end
            default: begin
                n_state = ST_READY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_READY;
            r_seq.one     <= SEQ_W'(1);
            r_seq.two     <= '0;
            r_skip_left   <= '0;
            r_pilot_count <= '0;
            r_run_active  <= 1'b0;
            r_later       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_seq         <= n_seq;
            r_skip_left   <= n_skip_left;
            r_pilot_count <= n_pilot_count;
            r_run_active  <= n_run_active;
            r_later       <= n_later;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cid_mod6   <= cid_mod6(i_cell_id);
        r_i_neg      <= n_i_neg;
        r_q_neg      <= n_q_neg;
        r_subcarrier <= n_subcarrier;
        r_last       <= n_last;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_i_neg      = r_i_neg;
    assign o_q_neg      = r_q_neg;
    assign o_subcarrier = r_subcarrier;
    assign o_last       = r_last;

endmodule
`default_nettype wire

FILE: sv/cell_reference_signal_gen_top.sv
// top level of the cell-specific reference signal pilot generator, antenna port 0
//
// A start transfer (tuser high) loads the gold sequence seed from slot, symbol, cell id and
// cyclic prefix mode, then the sequence engine fast-forwards 1600 + 2*(110 - rb_count)
// steps at two steps per cycle and gives no result. Every following continuation transfer
// gives one pilot from the sequence engine, which takes the two sequence bits of a pilot in
// the same cycle; with an empty queue a continuation is written into the command queue and
// then its pilot into the output register, and back to back continuations give one pilot
// per cycle while the output is not stalled. A two-entry command queue lets the input side
// take items while the engine fast-forwards or the output stalls. Continuations outside a
// run are dropped. rb_count is clamped to 1..110. Configuration is taken at once.
`default_nettype none
module cell_reference_signal_gen_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [crsg_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [crsg_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [crsg_pkg::IN_TDATA_W-1:0]   i_s_tdata,  // slot, symbol_sel, zero pad
    input  wire logic                              i_s_tuser,  // start_req
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [crsg_pkg::OUT_TDATA_W-1:0]       o_m_tdata,  // i_neg, q_neg, subcarrier, pad
    output logic                                   o_m_tlast   // last
);
    import crsg_pkg::*;

    logic [CID_W-1:0] r_cell_id;
    logic             r_extended_cp;
    logic [RB_W-1:0]  r_rb_count;

    logic             w_push;
    t_cmd             w_push_cmd;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    t_cmd             w_head_cmd;
    logic             w_i_neg;
    logic             w_q_neg;
    logic [SC_W-1:0]  w_subcarrier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_id     <= '0;
            r_extended_cp <= 1'b0;
            r_rb_count    <= RB_W'(RB_FULL);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CELL_ID:  r_cell_id     <= i_cfg_wdata[CID_W-1:0];
                CFG_EXT_CP:   r_extended_cp <= i_cfg_wdata[0];
                CFG_RB_COUNT: r_rb_count    <= i_cfg_wdata[RB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    crsg_front u_front (
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_slot        (i_s_tdata[SLOT_W-1:0]),
        .i_symbol_sel  (i_s_tdata[SLOT_W]),
        .i_start_req   (i_s_tuser),
        .i_cell_id     (r_cell_id),
        .i_extended_cp (r_extended_cp),
        .i_rb_count    (r_rb_count),
        .i_fifo_full   (w_full),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    crsg_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    crsg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell_id    (r_cell_id),
        .i_rb_count   (r_rb_count),
        .i_cmd_empty  (w_empty),
        .i_cmd        (w_head_cmd),
        .o_pop        (w_pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_i_neg      (w_i_neg),
        .o_q_neg      (w_q_neg),
        .o_subcarrier (w_subcarrier),
        .o_last       (o_m_tlast)
    );

    assign o_m_tdata = OUT_TDATA_W'({w_subcarrier, w_q_neg, w_i_neg});

endmodule
`default_nettype wire

FILE: sv/crsg_checker.sv
// port-level checks of the pilot generator and their binding to the top level
`default_nettype none
module crsg_port_checks (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    input  wire logic                              o_s_tready,
    input  wire logic                              o_m_tvalid,
    input  wire logic                              i_m_tready,
    input  wire logic [crsg_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    input  wire logic                              o_m_tlast
);
    import crsg_pkg::*;

    // stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output changed");

    // reset empties the output register
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // subcarrier stays inside the largest carrier
    a_sc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[SC_W+1:2] <= SC_W'(PILOT_SPACING * MAX_PILOTS / 2 * 2 - 1))
        else $error("subcarrier out of range");

    // input ready is only withdrawn after a transfer
    a_ready_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready && !i_s_tvalid |=> o_s_tready)
        else $error("input ready dropped without a transfer");

endmodule

bind cell_reference_signal_gen_top crsg_port_checks u_port_checks (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire
